// ----- src/vwbu_pkg.sv -----
// Package for the variable-width bit unpacker: item types, opcodes, defaults.
// No dependencies; used by every module of the block.
package vwbu_pkg;

  // Fixed field widths of the channels
  localparam int DATA_BITS  = 32;
  localparam int WIDTH_BITS = 6;
  localparam int CODE_BITS  = 32;

  // Defaults for top-level parameters
  localparam int WORD_BITS_DEF   = 32;
  localparam int QUEUE_DEPTH_DEF = 2;

  // Opcodes
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_UNPACK = 1'b1;

  // Input transfer payload
  typedef struct packed {
    logic                  opcode;
    logic [DATA_BITS-1:0]  data_word;
    logic [WIDTH_BITS-1:0] code_width;
  } in_item_t;

  // Output transfer payload
  typedef struct packed {
    logic [CODE_BITS-1:0] code;
    logic                 has_code;
  } out_item_t;

  // Classified command held in the queue between front and back
  typedef struct packed {
    logic                  is_unpack;
    logic [DATA_BITS-1:0]  data_word;
    logic [WIDTH_BITS-1:0] width;   // already saturated to the word size
  } cmd_t;

  // Handshake bundle between queue and back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_slot_t;

endpackage

// ----- src/variable_width_bit_unpacker.sv -----
// Top level of the MSB-first variable-width bit unpacker.
// Depends on vwbu_pkg, vwbu_front, vwbu_queue and vwbu_back.
//
//   channel | signals                        | payload
//   input   | in_valid / in_ready  / in_item | opcode, data_word, code_width
//   output  | out_valid / out_ready / out_item | code, has_code
//
// One item per cycle sustained while the queue is not full; an unpack result
// reaches the output through the queue and then the output register.
// Loads give no result. Reset (rst, synchronous) empties the queue and the
// output register and sets the fresh-word phase. An output stall holds the
// unpack at the queue head and everything behind it; a load at the head
// still drains. in_ready drops only when the queue is full.
module variable_width_bit_unpacker #(
  parameter int WORD_BITS   = vwbu_pkg::WORD_BITS_DEF,
  parameter int QUEUE_DEPTH = vwbu_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  vwbu_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output vwbu_pkg::out_item_t out_item
);

  logic                queue_full;
  logic                push;
  vwbu_pkg::cmd_t      push_cmd;
  vwbu_pkg::cmd_slot_t head;
  logic                pop;

  vwbu_front #(
    .WORD_BITS(WORD_BITS)
  ) u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .queue_full(queue_full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  vwbu_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_cmd(push_cmd),
    .full    (queue_full),
    .head    (head),
    .pop     (pop)
  );

  vwbu_back #(
    .WORD_BITS(WORD_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .pop      (pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

endmodule

// ----- src/vwbu_front.sv -----
// Front end: accepts input transfers, decodes the opcode and clamps the width.
// Depends on vwbu_pkg.
module vwbu_front #(
  parameter int WORD_BITS = vwbu_pkg::WORD_BITS_DEF
) (
  input  logic               in_valid,
  output logic               in_ready,
  input  vwbu_pkg::in_item_t in_item,
  input  logic               queue_full,
  output logic               push,
  output vwbu_pkg::cmd_t     push_cmd
);

  localparam logic [vwbu_pkg::WIDTH_BITS:0] W_CMP = (vwbu_pkg::WIDTH_BITS + 1)'(WORD_BITS);

  logic width_over;

  assign in_ready = !queue_full;
  assign push     = in_valid && !queue_full;

  // Widths above the word size clamp to the word size
  assign width_over = {1'b0, in_item.code_width} > W_CMP;

  always_comb begin
    push_cmd.is_unpack = (in_item.opcode == vwbu_pkg::OP_UNPACK);
    push_cmd.data_word = in_item.data_word;
    push_cmd.width     = width_over ? vwbu_pkg::WIDTH_BITS'(WORD_BITS) : in_item.code_width;
  end

endmodule

// ----- src/vwbu_queue.sv -----
// Short command queue that decouples the front end from the back end.
// Depends on vwbu_pkg.
module vwbu_queue #(
  parameter int DEPTH = vwbu_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  vwbu_pkg::cmd_t     push_cmd,
  output logic               full,
  output vwbu_pkg::cmd_slot_t head,
  input  logic               pop
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);
  localparam logic [PTR_BITS-1:0] LAST = PTR_BITS'(DEPTH - 1);
  localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

  vwbu_pkg::cmd_t      slots [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                do_pop;

  assign full       = (count == FULL_CNT);
  assign head.valid = (count != '0);
  assign head.cmd   = slots[rd_ptr];
  assign do_pop     = pop && head.valid;

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- src/vwbu_back.sv -----
// Back end: holds the word store and extraction state, executes commands,
// and keeps the output register. Depends on vwbu_pkg.
module vwbu_back #(
  parameter int WORD_BITS = vwbu_pkg::WORD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  vwbu_pkg::cmd_slot_t head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output vwbu_pkg::out_item_t out_item
);

  localparam logic [7:0] W_AMT = 8'(WORD_BITS);

  // Phase codes
  localparam logic [1:0] PH_ACTIVE   = 2'd0;
  localparam logic [1:0] PH_FRESH    = 2'd1;
  localparam logic [1:0] PH_BOUNDARY = 2'd2;

  logic [WORD_BITS-1:0] word_store, word_store_next;
  logic [WORD_BITS-1:0] partial_code, partial_code_next;
  logic [5:0]           bits_used, bits_used_next;
  logic [1:0]           phase, phase_next;

  logic [WORD_BITS-1:0] ws_eff;
  logic [WORD_BITS-1:0] part_eff;
  logic [WORD_BITS-1:0] taken;
  logic [WORD_BITS-1:0] res_code;
  logic                 res_got;
  logic [7:0]           used8;
  logic [7:0]           s8;
  logic [7:0]           sum8;
  logic                 out_free;

  // Shifts by the word size or more give zero
  function automatic logic [WORD_BITS-1:0] shl_w(input logic [WORD_BITS-1:0] v,
                                                  input logic [7:0] amt);
    logic [WORD_BITS-1:0] r;
    r = '0;
    if (amt < W_AMT) begin
      r = v << amt;
    end
    return r;
  endfunction

  function automatic logic [WORD_BITS-1:0] shr_w(input logic [WORD_BITS-1:0] v,
                                                  input logic [7:0] amt);
    logic [WORD_BITS-1:0] r;
    r = '0;
    if (amt < W_AMT) begin
      r = v >> amt;
    end
    return r;
  endfunction

  // Loads retire without a result; unpacks need a free output register
  assign out_free = !out_valid || out_ready;
  assign pop      = head.valid && (!head.cmd.is_unpack || out_free);

  // A fresh word is aligned past the bits already taken from the previous one
  assign used8    = {2'b00, bits_used};
  assign s8       = {2'b00, head.cmd.width};
  assign sum8     = used8 + s8;
  assign ws_eff   = (phase == PH_FRESH) ? shl_w(word_store, used8) : word_store;
  assign part_eff = (phase == PH_FRESH) ? word_store : partial_code;
  assign taken    = shr_w(ws_eff, W_AMT - s8);

  // Execute the command at the queue head: a load or one unpack
  always_comb begin
    word_store_next   = word_store;
    partial_code_next = partial_code;
    bits_used_next    = bits_used;
    phase_next        = phase;
    res_code          = '0;
    res_got           = 1'b1;
    if (!head.cmd.is_unpack) begin
      word_store_next = WORD_BITS'(head.cmd.data_word);
    end else begin
      word_store_next   = ws_eff;
      partial_code_next = part_eff;
      priority if (phase == PH_BOUNDARY) begin
        // finish a code that straddles the word boundary
        res_code   = partial_code | shr_w(word_store, W_AMT - used8);
        phase_next = PH_FRESH;
      end else if (sum8 < W_AMT) begin
        res_code        = taken;
        bits_used_next  = sum8[5:0];
        word_store_next = shl_w(ws_eff, s8);
        phase_next      = PH_ACTIVE;
      end else if (sum8 > W_AMT) begin
        // not enough bits left: keep the head, ask for a new word
        bits_used_next    = 6'(sum8 - W_AMT);
        partial_code_next = taken;
        phase_next        = PH_BOUNDARY;
        res_got           = 1'b0;
      end else begin
        // exact fit empties the store
        res_code          = taken;
        partial_code_next = taken;
        word_store_next   = '0;
        bits_used_next    = '0;
        phase_next        = PH_FRESH;
      end
    end
  end

  // Extraction state
  always_ff @(posedge clk) begin
    if (rst) begin
      word_store   <= '0;
      partial_code <= '0;
      bits_used    <= '0;
      phase        <= PH_FRESH;
    end else if (pop) begin
      word_store   <= word_store_next;
      partial_code <= partial_code_next;
      bits_used    <= bits_used_next;
      phase        <= phase_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && head.cmd.is_unpack) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.cmd.is_unpack) begin
      out_item.code     <= vwbu_pkg::CODE_BITS'(res_code);
      out_item.has_code <= res_got;
    end
  end

endmodule

// ----- src/vwbu_checker.sv -----
// Port-level checker for the bit unpacker, bound to the top level.
// Depends on vwbu_pkg and variable_width_bit_unpacker.
module vwbu_checker (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_ready,
  input vwbu_pkg::out_item_t out_item
);

  logic last_miss;

  // Remembers whether the last delivered result asked for a new word
  always_ff @(posedge clk) begin
    if (rst) begin
      last_miss <= 1'b0;
    end else if (out_valid && out_ready) begin
      last_miss <= !out_item.has_code;
    end
  end

  // No result straight out of reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  // A new-word request carries a zero code
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.has_code |-> out_item.code == '0)
    else $error("new-word request with nonzero code");

  // Two new-word requests never follow each other
  a_no_double_miss: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_miss |-> out_item.has_code)
    else $error("two new-word requests in a row");

endmodule

bind variable_width_bit_unpacker vwbu_checker u_vwbu_checker (
  .clk      (clk),
  .rst      (rst),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_item (out_item)
);

// ----- dv/tb_variable_width_bit_unpacker.sv -----
// Self-checking testbench for the MSB-first variable-width bit unpacker.
// Depends on vwbu_pkg and variable_width_bit_unpacker; directed table, then random
// load/unpack streams checked against a behavioral predictor under varied stalls.
module tb_variable_width_bit_unpacker;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WORD_W      = 32;
  localparam int STALL_LIMIT = 4000;
  localparam int RAND_ITEMS  = 400;
  localparam int MAX_SHOWN   = 10;

  // Predictor phase encoding
  localparam logic [1:0] ST_IN_USE = 2'd0;
  localparam logic [1:0] ST_FRESH  = 2'd1;
  localparam logic [1:0] ST_JOIN   = 2'd2;

  typedef struct {
    vwbu_pkg::in_item_t  item;
    bit                  typed;
    vwbu_pkg::out_item_t want;
  } stim_row_t;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  vwbu_pkg::in_item_t  in_item;
  logic                out_valid;
  logic                out_ready;
  vwbu_pkg::out_item_t out_item;

  // Predictor state
  logic [31:0] head_bits;
  logic [31:0] word_bits;
  logic [5:0]  used_bits;
  logic [1:0]  stage;

  vwbu_pkg::out_item_t pending_codes[$];
  stim_row_t           stim_table[$];
  vwbu_pkg::out_item_t seen_want;
  int                  bad_results = 0;
  int                  stall_cycles = 0;
  int                  snd_idle_pct;
  int                  rcv_idle_pct;

  variable_width_bit_unpacker dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Shifts that give zero for any amount outside the word
  function automatic logic [31:0] shl_word(logic [31:0] v, int amt);
    if (amt < 0 || amt >= WORD_W) return '0;
    return v << amt;
  endfunction

  function automatic logic [31:0] shr_word(logic [31:0] v, int amt);
    if (amt < 0 || amt >= WORD_W) return '0;
    return v >> amt;
  endfunction

  function automatic void unpacker_clear();
    head_bits = '0;
    word_bits = '0;
    used_bits = '0;
    stage     = ST_FRESH;
  endfunction

  // Advance the predictor by one item; returns 1 when the item gives a result
  function automatic bit unpack_step(input vwbu_pkg::in_item_t it,
                                     output vwbu_pkg::out_item_t res);
    int w;
    int u;
    res = '0;
    if (it.opcode == vwbu_pkg::OP_LOAD) begin
      word_bits = it.data_word;
      return 1'b0;
    end
    w = int'(it.code_width);
    if (w > WORD_W) w = WORD_W;
    // fresh word: drop the bits already consumed
    if (stage == ST_FRESH) begin
      head_bits = word_bits;
      word_bits = shl_word(word_bits, int'(used_bits));
      stage     = ST_IN_USE;
    end
    u = int'(used_bits);
    res.has_code = 1'b1;
    if (stage == ST_JOIN) begin
      res.code = head_bits | shr_word(word_bits, WORD_W - u);
      stage    = ST_FRESH;
    end else if (u + w < WORD_W) begin
      res.code  = shr_word(word_bits, WORD_W - w);
      used_bits = 6'(u + w);
      word_bits = shl_word(word_bits, w);
      stage     = ST_IN_USE;
    end else if (u + w > WORD_W) begin
      used_bits    = 6'(u + w - WORD_W);
      head_bits    = shr_word(word_bits, WORD_W - w);
      stage        = ST_JOIN;
      res.has_code = 1'b0;
    end else begin
      // exact fit empties the word
      res.code  = shr_word(word_bits, WORD_W - w);
      head_bits = res.code;
      word_bits = '0;
      used_bits = '0;
      stage     = ST_FRESH;
    end
    return 1'b1;
  endfunction

  function automatic void add_row(logic op, logic [31:0] data, logic [5:0] width,
                                  bit typed, logic [31:0] code, logic has);
    stim_row_t r;
    r.item.opcode     = op;
    r.item.data_word  = data;
    r.item.code_width = width;
    r.typed           = typed;
    r.want.code       = code;
    r.want.has_code   = has;
    stim_table.push_back(r);
  endfunction

  // Random item shaped by where the stream stands: loads mostly when a word is due
  function automatic vwbu_pkg::in_item_t pick_item();
    vwbu_pkg::in_item_t it;
    int                 load_pct;
    int                 r;
    it.data_word  = $urandom;
    it.code_width = 6'($urandom_range(63, 0));
    unique case (stage)
      ST_JOIN:  load_pct = 85;
      ST_FRESH: load_pct = 55;
      default:  load_pct = 20;
    endcase
    if ($urandom_range(99, 0) < load_pct) begin
      it.opcode = vwbu_pkg::OP_LOAD;
    end else begin
      it.opcode = vwbu_pkg::OP_UNPACK;
      r = $urandom_range(99, 0);
      if (r < 6)       it.code_width = 6'd0;
      else if (r < 12) it.code_width = 6'($urandom_range(63, 33));
      else if (r < 20) it.code_width = 6'd32;
      else             it.code_width = 6'($urandom_range(31, 1));
    end
    return it;
  endfunction

  // One input transfer, with random idle cycles ahead of it
  task automatic send_item(vwbu_pkg::in_item_t it, bit typed, vwbu_pkg::out_item_t want);
    vwbu_pkg::out_item_t res;
    if ($urandom_range(99, 0) < snd_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99, 0) < snd_idle_pct);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    if (unpack_step(it, res)) pending_codes.push_back(typed ? want : res);
  endtask

  // Hold the sender off until every expected code has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk);
  endtask

  // Receiver stalls
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99, 0) >= rcv_idle_pct);
  end

  // Output checker and watchdog
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_codes.size() == 0) begin
        if (bad_results < MAX_SHOWN)
          $display("unexpected result: code=%h has_code=%b", out_item.code,
                   out_item.has_code);
        bad_results++;
      end else begin
        seen_want = pending_codes.pop_front();
        if (out_item.code !== seen_want.code ||
            out_item.has_code !== seen_want.has_code) begin
          if (bad_results < MAX_SHOWN)
            $display("mismatch: code exp=%h got=%h, has_code exp=%b got=%b",
                     seen_want.code, out_item.code, seen_want.has_code,
                     out_item.has_code);
          bad_results++;
        end
      end
    end
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int idle_snd[3];
    int idle_rcv[3];
    vwbu_pkg::out_item_t none;
    none         = '0;
    idle_snd     = '{33, 69, 0};
    idle_rcv     = '{69, 33, 0};
    snd_idle_pct = idle_snd[0];
    rcv_idle_pct = idle_rcv[0];
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_item   <= '0;
    out_ready <= 1'b0;
    unpacker_clear();

    // Directed stimulus; typed expectations only where obvious
    add_row(vwbu_pkg::OP_UNPACK, 32'h0,        6'd0,  1, 32'h0,        1'b1); // zero width
    add_row(vwbu_pkg::OP_UNPACK, 32'hFFFFFFFF, 6'd63, 1, 32'h0,        1'b1); // saturated
    add_row(vwbu_pkg::OP_LOAD,   32'hFFFFFFFF, 6'd63, 0, 32'h0,        1'b0);
    add_row(vwbu_pkg::OP_UNPACK, 32'h0,        6'd32, 1, 32'hFFFFFFFF, 1'b1); // full word
    add_row(vwbu_pkg::OP_UNPACK, 32'h0,        6'd1,  1, 32'h0,        1'b1); // no load
    add_row(vwbu_pkg::OP_LOAD,   32'h80000001, 6'd0,  0, 32'h0,        1'b0);
    add_row(vwbu_pkg::OP_UNPACK, 32'h0,        6'd4,  0, 32'h0,        1'b0);
    add_row(vwbu_pkg::OP_UNPACK, 32'h0,        6'd40, 1, 32'h0,        1'b0); // word needed
    add_row(vwbu_pkg::OP_LOAD,   32'hA5A5A5A5, 6'd0,  0, 32'h0,        1'b0);
    add_row(vwbu_pkg::OP_UNPACK, 32'h0,        6'd7,  0, 32'h0,        1'b0); // boundary join
    add_row(vwbu_pkg::OP_UNPACK, 32'h0,        6'd16, 0, 32'h0,        1'b0);
    add_row(vwbu_pkg::OP_LOAD,   32'h00000000, 6'd0,  0, 32'h0,        1'b0);
    add_row(vwbu_pkg::OP_UNPACK, 32'h0,        6'd0,  0, 32'h0,        1'b0); // zero mid-word
    add_row(vwbu_pkg::OP_UNPACK, 32'h0,        6'd11, 0, 32'h0,        1'b0); // ends at end
    add_row(vwbu_pkg::OP_LOAD,   32'h12345678, 6'd0,  0, 32'h0,        1'b0);
    add_row(vwbu_pkg::OP_UNPACK, 32'h0,        6'd31, 0, 32'h0,        1'b0);
    add_row(vwbu_pkg::OP_UNPACK, 32'h0,        6'd1,  0, 32'h0,        1'b0); // exact fit
    add_row(vwbu_pkg::OP_UNPACK, 32'h0,        6'd33, 0, 32'h0,        1'b0);
    add_row(vwbu_pkg::OP_LOAD,   32'hDEADBEEF, 6'd0,  0, 32'h0,        1'b0);
    add_row(vwbu_pkg::OP_UNPACK, 32'h0,        6'd20, 0, 32'h0,        1'b0);
    add_row(vwbu_pkg::OP_UNPACK, 32'h0,        6'd20, 1, 32'h0,        1'b0); // word needed
    add_row(vwbu_pkg::OP_UNPACK, 32'h0,        6'd5,  0, 32'h0,        1'b0); // join, no load
    add_row(vwbu_pkg::OP_LOAD,   32'hFFFFFFFF, 6'd0,  0, 32'h0,        1'b0);
    add_row(vwbu_pkg::OP_UNPACK, 32'h0,        6'd63, 0, 32'h0,        1'b0);
    add_row(vwbu_pkg::OP_LOAD,   32'h00000000, 6'd0,  0, 32'h0,        1'b0);
    add_row(vwbu_pkg::OP_UNPACK, 32'h0,        6'd1,  0, 32'h0,        1'b0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_table[i]) send_item(stim_table[i].item, stim_table[i].typed,
                                      stim_table[i].want);

    // Random streams under three stall profiles, drained between them
    for (int ph = 0; ph < 3; ph++) begin
      drain_results();
      snd_idle_pct = idle_snd[ph];
      rcv_idle_pct = idle_rcv[ph];
      for (int n = 0; n < RAND_ITEMS / 3 + 1; n++) send_item(pick_item(), 1'b0, none);
    end

    in_valid <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (bad_results == 0 && pending_codes.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/vwbu_pkg.sv
src/vwbu_front.sv
src/vwbu_queue.sv
src/vwbu_back.sv
src/variable_width_bit_unpacker.sv
src/vwbu_checker.sv
dv/tb_variable_width_bit_unpacker.sv
